// File: src/rrhb_pkg.sv
// Shared types and codes for the reversible ring history buffer.
`default_nettype none

package rrhb_pkg;

  // Operation codes carried on the cmd field.
  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_READ    = 2'd2,
    CMD_REVERSE = 2'd3
  } cmd_e_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_POS   = 2'd3
  } status_e_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WAIT = 2'd2,
    S_OUT  = 2'd3
  } state_t;

  localparam int HDG_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the incoming word
    logic exec;     // check, update pointers, access the ring
    logic capture;  // take the registered read data into the result
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read;  // current operation returns a stored entry
  } dp_sts_t;

endpackage

`default_nettype wire

// File: src/rrhb_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none

module rrhb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: src/rrhb_ctrl.sv
// Controller state machine for the reversible ring history buffer.
`default_nettype none

module rrhb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  input  wire rrhb_pkg::dp_sts_t sts,
  output rrhb_pkg::ctl_t         ctl
);

  rrhb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrhb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rrhb_pkg::S_IDLE: begin
        if (cmd_valid) state_next = rrhb_pkg::S_EXEC;
      end
      rrhb_pkg::S_EXEC: begin
        state_next = sts.needs_read ? rrhb_pkg::S_WAIT : rrhb_pkg::S_OUT;
      end
      rrhb_pkg::S_WAIT: begin
        state_next = rrhb_pkg::S_OUT;
      end
      rrhb_pkg::S_OUT: begin
        if (!rsp_stall) state_next = rrhb_pkg::S_IDLE;
      end
      default: begin
        state_next = rrhb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_stall   = 1'b1;
    rsp_valid   = 1'b0;
    ctl.load    = 1'b0;
    ctl.exec    = 1'b0;
    ctl.capture = 1'b0;
    unique case (state)
      rrhb_pkg::S_IDLE: begin
        cmd_stall = 1'b0;
        ctl.load  = cmd_valid;
      end
      rrhb_pkg::S_EXEC: begin
        ctl.exec = 1'b1;
      end
      rrhb_pkg::S_WAIT: begin
        ctl.capture = 1'b1;
      end
      rrhb_pkg::S_OUT: begin
        rsp_valid = 1'b1;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/rrhb_dp.sv
// Datapath: pointers, count, ring storage and result registers.
`default_nettype none

module rrhb_dp #(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rrhb_pkg::ctl_t                    ctl,
  output rrhb_pkg::dp_sts_t                      sts,
  input  wire logic [1:0]                        cmd,
  input  wire logic [ID_BITS-1:0]                track_id,
  input  wire logic signed [rrhb_pkg::HDG_W-1:0] heading,
  input  wire logic [$clog2(DEPTH)-1:0]          position,
  output logic [1:0]                             status,
  output logic [ID_BITS-1:0]                     track_id_out,
  output logic signed [rrhb_pkg::HDG_W-1:0]      heading_out,
  output logic [$clog2(DEPTH+1)-1:0]             count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int HW    = rrhb_pkg::HDG_W;
  localparam int MEM_W = ID_BITS + HW;
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic signed [HW-1:0] HDG_MIN = {1'b1, {(HW - 1){1'b0}}};

  // Latched operation.
  rrhb_pkg::cmd_e_t       cmd_q;
  logic [ID_BITS-1:0]     id_q;
  logic signed [HW-1:0]   hdg_q;
  logic [PTR_W-1:0]       pos_q;

  // Architectural state.
  logic [PTR_W-1:0] head;
  logic             step_neg;
  logic [CNT_W-1:0] fill;

  // Result registers.
  rrhb_pkg::status_e_t  status_q;
  logic [ID_BITS-1:0]   id_out_q;
  logic signed [HW-1:0] hdg_out_q;

  rrhb_pkg::status_e_t  status_c;
  logic [PTR_W-1:0]     ahead;
  logic [PTR_W-1:0]     back_b;
  logic [PTR_W-1:0]     back_addr;
  logic [PTR_W:0]       sum_x;
  logic [PTR_W:0]       wrap_x;
  logic signed [HW-1:0] hdg_sat;
  logic signed [HW-1:0] hdg_store;
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_addr;
  logic [MEM_W-1:0]     ram_rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic signed [HW-1:0] rd_hdg;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= rrhb_pkg::cmd_e_t'(cmd);
      id_q  <= track_id;
      hdg_q <= heading;
      pos_q <= position;
    end
  end

  // Error check against the count held before the operation.
  always_comb begin
    status_c = rrhb_pkg::ST_OK;
    unique case (cmd_q)
      rrhb_pkg::CMD_APPEND: if (fill >= FULL_CNT) status_c = rrhb_pkg::ST_FULL;
      rrhb_pkg::CMD_REMOVE: if (fill == '0) status_c = rrhb_pkg::ST_EMPTY;
      rrhb_pkg::CMD_READ:   if (CNT_W'(pos_q) >= fill) status_c = rrhb_pkg::ST_POS;
      default:              status_c = rrhb_pkg::ST_OK;
    endcase
  end

  assign sts.needs_read = (status_c == rrhb_pkg::ST_OK) &&
                          ((cmd_q == rrhb_pkg::CMD_REMOVE) || (cmd_q == rrhb_pkg::CMD_READ));

  // Slot one step ahead of the head.
  always_comb begin
    if (step_neg) begin
      ahead = (head == '0) ? LAST_PTR : head - PTR_W'(1);
    end else begin
      ahead = (head == LAST_PTR) ? '0 : head + PTR_W'(1);
    end
  end

  // Slot a given distance behind the head; the distance is below DEPTH.
  always_comb begin
    back_b = (cmd_q == rrhb_pkg::CMD_READ) ? pos_q : PTR_W'(fill - CNT_W'(1));
    sum_x  = {1'b0, head} + {1'b0, back_b};
    wrap_x = {1'b0, head} + DEPTH_X - {1'b0, back_b};
    if (step_neg) begin
      back_addr = (sum_x >= DEPTH_X) ? PTR_W'(sum_x - DEPTH_X) : sum_x[PTR_W-1:0];
    end else begin
      back_addr = (head >= back_b) ? head - back_b : wrap_x[PTR_W-1:0];
    end
  end

  // The most negative heading is clipped so that negation stays in range.
  always_comb begin
    hdg_sat   = (hdg_q == HDG_MIN) ? HDG_MIN + HW'(1) : hdg_q;
    hdg_store = step_neg ? -hdg_sat : hdg_sat;
  end

  assign ram_we   = ctl.exec && (cmd_q == rrhb_pkg::CMD_APPEND) &&
                    (status_c == rrhb_pkg::ST_OK);
  assign ram_addr = (cmd_q == rrhb_pkg::CMD_APPEND) ? ahead : back_addr;

  rrhb_ram #(
    .WIDTH(MEM_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata({id_q, hdg_store}),
    .rdata(ram_rdata)
  );

  assign rd_id  = ram_rdata[MEM_W-1:HW];
  assign rd_hdg = ram_rdata[HW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      step_neg <= 1'b0;
      fill     <= '0;
    end else if (ctl.exec && (status_c == rrhb_pkg::ST_OK)) begin
      unique case (cmd_q)
        rrhb_pkg::CMD_APPEND: begin
          head <= ahead;
          fill <= fill + CNT_W'(1);
        end
        rrhb_pkg::CMD_REMOVE: begin
          fill <= fill - CNT_W'(1);
        end
        rrhb_pkg::CMD_READ: begin
          fill <= fill;
        end
        rrhb_pkg::CMD_REVERSE: begin
          head     <= (fill == '0) ? ahead : back_addr;
          step_neg <= ~step_neg;
        end
        default: begin
          fill <= fill;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status_q  <= status_c;
      id_out_q  <= '0;
      hdg_out_q <= '0;
    end else if (ctl.capture) begin
      id_out_q  <= rd_id;
      hdg_out_q <= step_neg ? -rd_hdg : rd_hdg;
    end
  end

  assign status       = status_q;
  assign track_id_out = id_out_q;
  assign heading_out  = hdg_out_q;
  assign count        = fill;

endmodule

`default_nettype wire

// File: src/reversible_ring_history_buffer_top.sv
// Top level of the reversible ring history buffer.
//
// The block keeps a ring of DEPTH entries, each a track identifier and a
// signed heading, and runs one operation per input word: append, remove the
// oldest entry, read the entry a given distance back from the newest, or
// reverse the order of the history.
// The command channel (cmd_valid, cmd_stall) takes a word whenever the block
// is idle; the response channel (rsp_valid, rsp_stall) returns exactly one
// word per command, carrying the status, the returned entry and the count.
// A command is executed in the cycle after it is accepted. Append, reverse
// and any error show their response in the cycle after that; remove and read
// first pass through a wait state for the registered read of the ring memory.
// No new command is accepted until the response to the last one has left,
// as the controller handles one command at a time over a single memory port.
// While the receiver stalls, the response word holds and no new command is
// taken. Reset empties the buffer at once, with the head at slot zero and
// the step positive; the ring memory itself is not cleared, since only
// entries inside the count are ever read.
`default_nettype none

module reversible_ring_history_buffer_top #(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_stall,
  input  wire logic [1:0]                        cmd,
  input  wire logic [ID_BITS-1:0]                track_id,
  input  wire logic signed [rrhb_pkg::HDG_W-1:0] heading,
  input  wire logic [$clog2(DEPTH)-1:0]          position,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic [1:0]                             status,
  output logic [ID_BITS-1:0]                     track_id_out,
  output logic signed [rrhb_pkg::HDG_W-1:0]      heading_out,
  output logic [$clog2(DEPTH+1)-1:0]             count
);

  // Control commands and datapath status between the two halves.
  rrhb_pkg::ctl_t    ctl;
  rrhb_pkg::dp_sts_t sts;

  // The controller sequences accept, execute, read wait and response.
  rrhb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // The datapath holds the pointers, count, ring memory and response word.
  rrhb_dp #(
    .DEPTH  (DEPTH),
    .ID_BITS(ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cmd         (cmd),
    .track_id    (track_id),
    .heading     (heading),
    .position    (position),
    .status      (status),
    .track_id_out(track_id_out),
    .heading_out (heading_out),
    .count       (count)
  );

endmodule

`default_nettype wire
